// ----- src/wbps_pkg.sv -----
// shared types and constants of the wildcard byte pattern scanner
package wbps_pkg;

	localparam int PAT_BYTES      = 32;
	localparam int DATA_BITS      = 8;
	localparam int LEN_BITS       = 6;
	localparam int MASK_BITS      = 32;
	localparam int OFFSET_OUT_BITS = 32;
	localparam int CFG_DATA_BITS  = 64;
	localparam int CFG_INDEX_BITS = 3;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_CNT_BITS = 2;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_0 = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_1 = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_2 = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_3 = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WILDCARD  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH    = 3'd5;

	typedef struct packed {
		logic [PAT_BYTES-1:0][DATA_BITS-1:0] pattern;
		logic [MASK_BITS-1:0]                wild;
		logic [LEN_BITS-1:0]                 length;
	} cfg_t;

	// one classified byte handed from the front to the back
	typedef struct packed {
		logic                       hit;
		logic                       first;
		logic                       last;
		logic [OFFSET_OUT_BITS-1:0] offset;
	} entry_t;

endpackage

// ----- src/wbps_front.sv -----
// front: byte window, byte counter and parallel masked compare
module wbps_front #(
	parameter int PATTERN_MAX_BYTES = 32,
	parameter int OFFSET_BITS       = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       region_start,
	input  logic                       region_end,
	input  wbps_pkg::cfg_t             cfg,
	output logic                       push_valid,
	input  logic                       push_ready,
	output wbps_pkg::entry_t           push_entry
);
	import wbps_pkg::*;

	localparam int LW = $clog2(PATTERN_MAX_BYTES + 1);
	localparam int IW = (PATTERN_MAX_BYTES > 1) ? $clog2(PATTERN_MAX_BYTES) : 1;

	logic [DATA_BITS-1:0]   window_q [PATTERN_MAX_BYTES];
	logic [OFFSET_BITS-1:0] count_q;
	logic                   valid_s1;
	logic                   first_s1;
	logic                   last_s1;
	logic                   fire;
	logic [LW-1:0]          len_a;
	logic                   hit;
	logic [OFFSET_BITS-1:0] diff;

	assign in_ready = !valid_s1 || push_ready;
	assign fire     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			count_q  <= '0;
		end else if (fire) begin
			valid_s1 <= 1'b1;
			if (region_start) begin
				count_q <= OFFSET_BITS'(1);
			end else if (count_q != '1) begin
				count_q <= count_q + OFFSET_BITS'(1);
			end
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// window bytes older than the region are never compared, so no clearing
	always_ff @(posedge clk) begin
		if (fire) begin
			first_s1 <= region_start;
			last_s1  <= region_end;
			window_q[0] <= data_byte;
			for (int i = 1; i < PATTERN_MAX_BYTES; i++) begin
				window_q[i] <= window_q[i-1];
			end
		end
	end

	always_comb begin
		logic [DATA_BITS-1:0] pb;
		logic                 wb;
		logic [IW-1:0]        idx;
		if (int'(cfg.length) > PATTERN_MAX_BYTES) begin
			len_a = LW'(PATTERN_MAX_BYTES);
		end else begin
			len_a = LW'(cfg.length);
		end
		hit = (len_a != '0) && (count_q >= OFFSET_BITS'(len_a));
		for (int j = 0; j < PATTERN_MAX_BYTES; j++) begin
			if (j < PAT_BYTES) begin
				pb = cfg.pattern[j[4:0]];
				wb = cfg.wild[j[4:0]];
			end else begin
				pb = '0;
				wb = 1'b0;
			end
			idx = IW'(int'(len_a) - 1 - j);
			if ((LW'(j) < len_a) && !wb && (pb != window_q[idx])) begin
				hit = 1'b0;
			end
		end
	end

	assign diff = count_q - OFFSET_BITS'(len_a);

	assign push_valid        = valid_s1;
	assign push_entry.hit    = hit;
	assign push_entry.first  = first_s1;
	assign push_entry.last   = last_s1;
	assign push_entry.offset = OFFSET_OUT_BITS'(diff);

`ifndef SYNTH
	a_start_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && region_start |=> count_q == OFFSET_BITS'(1))
		else $error("counter not restarted by region start");
`endif

endmodule

// ----- src/wbps_queue.sv -----
// short queue between the front and the back
module wbps_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  wbps_pkg::entry_t push_entry,
	output logic             pop_valid,
	input  logic             pop_ready,
	output wbps_pkg::entry_t pop_entry
);
	import wbps_pkg::*;

	entry_t                    slot_q [QUEUE_DEPTH];
	logic                      wr_ptr_q;
	logic                      rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;
	logic                      push;
	logic                      pop;

	assign push_ready = count_q != QUEUE_CNT_BITS'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_entry  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

`ifndef SYNTH
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
		else $error("queue fill beyond depth");
`endif

endmodule

// ----- src/wbps_back.sv -----
// back: done flag per region and the result register
module wbps_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pop_valid,
	output logic                                 pop_ready,
	input  wbps_pkg::entry_t                     pop_entry,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 found,
	output logic [wbps_pkg::OFFSET_OUT_BITS-1:0] match_offset
);
	import wbps_pkg::*;

	logic                       done_q;
	logic                       out_valid_q;
	logic                       found_q;
	logic [OFFSET_OUT_BITS-1:0] offset_q;
	logic                       pop;
	logic                       done_eff;
	logic                       emit;

	assign pop_ready = !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;
	assign done_eff  = pop_entry.first ? 1'b0 : done_q;
	assign emit      = pop && !done_eff && (pop_entry.hit || pop_entry.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				done_q <= done_eff || emit;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q  <= pop_entry.hit;
			offset_q <= pop_entry.hit ? pop_entry.offset : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

`ifndef SYNTH
	a_done_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> done_q)
		else $error("region not closed after its result");
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> offset_q == '0)
		else $error("not-found beat carries an offset");
`endif

endmodule

// ----- src/wildcard_byte_pattern_scanner.sv -----
// top level of the wildcard byte pattern scanner
// usage
//   the input channel (in_valid/in_ready) takes one region byte per beat with
//   region_start on the first byte and region_end on the last; bytes before the
//   first region_start form a region that begins at reset
//   the output channel (out_valid/out_ready) gives at most one beat per region:
//   found=1 with the region offset of the first match, or found=0 and offset 0
//   when the region ends without one
//   configuration writes (cfg_we, cfg_index, cfg_wdata) go in while the block
//   is idle; indexes above the length register are dropped
// timing
//   one byte per cycle sustained while the queue has room, set by the masked
//   compare of the whole window against the pattern in the front stage
//   from byte accept to result beat a byte passes the compare stage, the
//   two-entry queue and the result register
// reset and stalls
//   reset clears the pattern, mask, length, counter and done flag
//   a stalled receiver holds the result register; the back then stops draining
//   the queue and the front keeps taking bytes until the queue fills
module wildcard_byte_pattern_scanner #(
	parameter int PATTERN_MAX_BYTES = 32,
	parameter int OFFSET_BITS       = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           data_byte,
	input  logic                                 region_start,
	input  logic                                 region_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 found,
	output logic [wbps_pkg::OFFSET_OUT_BITS-1:0] match_offset,
	input  logic                                 cfg_we,
	input  logic [wbps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [wbps_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
	import wbps_pkg::*;

	// configuration registers
	logic [3:0][CFG_DATA_BITS-1:0] pattern_q;
	logic [MASK_BITS-1:0]          wild_q;
	logic [LEN_BITS-1:0]           length_q;
	cfg_t                          cfg;

	// front to queue and queue to back
	logic   push_valid;
	logic   push_ready;
	entry_t push_entry;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			wild_q    <= '0;
			length_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_0: pattern_q[0] <= cfg_wdata;
				REG_PATTERN_1: pattern_q[1] <= cfg_wdata;
				REG_PATTERN_2: pattern_q[2] <= cfg_wdata;
				REG_PATTERN_3: pattern_q[3] <= cfg_wdata;
				REG_WILDCARD:  wild_q       <= cfg_wdata[MASK_BITS-1:0];
				REG_LENGTH:    length_q     <= cfg_wdata[LEN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// byte j of the pattern sits in bits 8j+7..8j of the packed words
	assign cfg.pattern = pattern_q;
	assign cfg.wild    = wild_q;
	assign cfg.length  = length_q;

	wbps_front #(
		.PATTERN_MAX_BYTES(PATTERN_MAX_BYTES),
		.OFFSET_BITS      (OFFSET_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.region_start(region_start),
		.region_end  (region_end),
		.cfg         (cfg),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_entry  (push_entry)
	);

	// decouples the compare stage from the result register
	wbps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	// one result per region, held until the receiver takes the beat
	wbps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_entry   (pop_entry),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.match_offset(match_offset)
	);

endmodule
